// ----- rtl/sfpp_pkg.sv -----
// sfpp_pkg: shared types and constants of the sync framed packet parser
// used by sfpp_parse_core and sync_framed_packet_parser_unit, no dependencies
package sfpp_pkg;

	// parse phase codes, also reported on phase_after
	typedef enum logic [3:0] {
		PH_HUNT    = 4'd0,
		PH_SENDER  = 4'd1,
		PH_TARGET  = 4'd2,
		PH_COMMAND = 4'd3,
		PH_LENGTH  = 4'd4,
		PH_PAYLOAD = 4'd5,
		PH_CHK_HI  = 4'd6,
		PH_CHK_LO  = 4'd7,
		PH_DONE    = 4'd8
	} phase_t;

	localparam logic [7:0] SYNC_RESET = 8'hAA;

	// captured header fields and check word of the current frame
	typedef struct packed {
		logic [7:0]  src_id;
		logic [7:0]  dst_id;
		logic [7:0]  command;
		logic [15:0] check_word;
	} hdr_t;

endpackage

// ----- rtl/sfpp_parse_core.sv -----
// sfpp_parse_core: frame parse state and the per-byte next-state logic
// depends on sfpp_pkg; driven by sync_framed_packet_parser_unit
module sfpp_parse_core #(
	parameter int MAX_PAYLOAD = 64,
	parameter int LEN_W = 7,
	parameter int IDX_W = 6
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  logic [7:0]           rx_byte,
	input  logic [7:0]           sync_value,
	output sfpp_pkg::phase_t     phase_nx,
	output logic                 pay_valid,
	output logic [IDX_W-1:0]     pay_index,
	output logic                 done,
	output sfpp_pkg::hdr_t       hdr_nx,
	output logic [LEN_W-1:0]     len_nx
);
	import sfpp_pkg::*;

	localparam logic [7:0]       MAX_B = 8'(MAX_PAYLOAD);
	localparam logic [LEN_W-1:0] MAX_L = LEN_W'(MAX_PAYLOAD);

	phase_t           phase_q;
	hdr_t             hdr_q;
	logic [LEN_W-1:0] len_q;
	logic [LEN_W-1:0] cnt_q;
	logic [LEN_W-1:0] cnt_nx;
	logic [LEN_W-1:0] len_clamp;
	logic [LEN_W-1:0] cnt_inc;

	assign len_clamp = (rx_byte > MAX_B) ? MAX_L : LEN_W'(rx_byte);
	assign cnt_inc   = cnt_q + LEN_W'(1);

	// next state for one received byte
	always_comb begin
		phase_nx  = phase_q;
		hdr_nx    = hdr_q;
		len_nx    = len_q;
		cnt_nx    = cnt_q;
		pay_valid = 1'b0;
		pay_index = '0;
		done      = 1'b0;
		case (phase_q)
			PH_HUNT: begin
				if (rx_byte == sync_value) begin
					hdr_nx   = '0;
					len_nx   = '0;
					cnt_nx   = '0;
					phase_nx = PH_SENDER;
				end
			end
			PH_SENDER: begin
				hdr_nx.src_id = rx_byte;
				phase_nx = PH_TARGET;
			end
			PH_TARGET: begin
				hdr_nx.dst_id = rx_byte;
				phase_nx = PH_COMMAND;
			end
			PH_COMMAND: begin
				hdr_nx.command = rx_byte;
				phase_nx = PH_LENGTH;
			end
			PH_LENGTH: begin
				len_nx   = len_clamp;
				phase_nx = (len_clamp == '0) ? PH_CHK_HI : PH_PAYLOAD;
			end
			PH_PAYLOAD: begin
				pay_valid = 1'b1;
				pay_index = cnt_q[IDX_W-1:0];
				cnt_nx    = cnt_inc;
				if (cnt_inc >= len_q) begin
					phase_nx = PH_CHK_HI;
				end
			end
			PH_CHK_HI: begin
				hdr_nx.check_word = {rx_byte, 8'h00};
				phase_nx = PH_CHK_LO;
			end
			PH_CHK_LO: begin
				hdr_nx.check_word = hdr_q.check_word + {8'h00, rx_byte};
				done     = 1'b1;
				phase_nx = PH_DONE;
			end
			default: begin
				// byte after done is swallowed
				phase_nx = PH_HUNT;
			end
		endcase
	end

	// parse state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			hdr_q   <= '0;
			len_q   <= '0;
			cnt_q   <= '0;
		end else if (step) begin
			phase_q <= phase_nx;
			hdr_q   <= hdr_nx;
			len_q   <= len_nx;
			cnt_q   <= cnt_nx;
		end
	end

endmodule

// ----- rtl/sync_framed_packet_parser_unit.sv -----
// sync_framed_packet_parser_unit: top level of the sync framed packet parser
// depends on sfpp_pkg and sfpp_parse_core
//
// Parses a byte stream into frames: sync byte, sender, target, command, length
// (clamped to MAX_PAYLOAD), payload bytes reported one per transaction with
// their index, then a big-endian check word that is captured but not checked.
// Every accepted byte yields exactly one result transaction. Throughput is one
// byte per clock while out_ready does not stall the result register; a byte
// passes through the input register, then the parse state update into the
// result register, which drives out_valid.
// Write sync_value via cfg_we/cfg_wdata only while no transaction
// is in flight; it resets to 0xAA.
module sync_framed_packet_parser_unit #(
	parameter int MAX_PAYLOAD = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  phase_after,
	output logic        payload_valid,
	output logic [7:0]  payload_byte,
	output logic [((MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1)-1:0] payload_index,
	output logic        frame_done,
	output logic [7:0]  src_id,
	output logic [7:0]  dst_id,
	output logic [7:0]  command,
	output logic [$clog2(MAX_PAYLOAD + 1)-1:0] payload_length,
	output logic [15:0] check_word
);
	import sfpp_pkg::*;

	localparam int LEN_W = $clog2(MAX_PAYLOAD + 1);
	localparam int IDX_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

	logic             v_s1;
	logic [7:0]       byte_s1;
	logic             v_s2;
	logic             advance;
	logic [7:0]       sync_q;
	phase_t           phase_nx;
	logic             pay_valid;
	logic [IDX_W-1:0] pay_index;
	logic             done;
	hdr_t             hdr_nx;
	logic [LEN_W-1:0] len_nx;

	// stage 1 moves on when the result register is free or being drained
	assign advance   = v_s1 && (!v_s2 || out_ready);
	assign in_ready  = !v_s1 || advance;
	assign out_valid = v_s2;

	// sync byte register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_q <= SYNC_RESET;
		end else if (cfg_we) begin
			sync_q <= cfg_wdata;
		end
	end

	// valid bits of the two stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				v_s1 <= in_valid;
			end
			if (advance) begin
				v_s2 <= 1'b1;
			end else if (out_ready) begin
				v_s2 <= 1'b0;
			end
		end
	end

	// input register
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= rx_byte;
		end
	end

	sfpp_parse_core #(
		.MAX_PAYLOAD(MAX_PAYLOAD),
		.LEN_W      (LEN_W),
		.IDX_W      (IDX_W)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.rx_byte   (byte_s1),
		.sync_value(sync_q),
		.phase_nx  (phase_nx),
		.pay_valid (pay_valid),
		.pay_index (pay_index),
		.done      (done),
		.hdr_nx    (hdr_nx),
		.len_nx    (len_nx)
	);

	// result register
	always_ff @(posedge clk) begin
		if (advance) begin
			phase_after    <= phase_nx;
			payload_valid  <= pay_valid;
			payload_byte   <= pay_valid ? byte_s1 : 8'h00;
			payload_index  <= pay_index;
			frame_done     <= done;
			src_id         <= hdr_nx.src_id;
			dst_id         <= hdr_nx.dst_id;
			command        <= hdr_nx.command;
			payload_length <= len_nx;
			check_word     <= hdr_nx.check_word;
		end
	end

	// a completed frame always lands in the done phase
	a_done_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && frame_done) |-> (phase_after == PH_DONE))
		else $error("frame_done without done phase");

	// a payload byte and frame completion never share a transaction
	a_pay_done_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(payload_valid && frame_done))
		else $error("payload_valid and frame_done together");

	// payload index stays below the clamped length
	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && payload_valid) |->
		(LEN_W'(payload_index) < payload_length))
		else $error("payload_index out of range");

	// input backpressure only when both stages are full and output stalls
	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (v_s1 && v_s2 && !out_ready))
		else $error("in_ready low without a full stall");

endmodule

// ----- verif/sync_framed_packet_parser_unit_tb.sv -----
// sync_framed_packet_parser_unit_tb: self-checking testbench for the sync framed packet parser
// depends on sfpp_pkg and sync_framed_packet_parser_unit; a scoreboard class predicts every
// result from the accepted bytes, and random frames, line noise and stalls drive the block
module sync_framed_packet_parser_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import sfpp_pkg::*;

	localparam int MAX_LEN = 64;
	localparam int HOLD_CYCLES = 300;
	localparam int QUIET_LIMIT = 3000;

	// bytes sent right after reset: ignored while hunting, zero length frame with
	// a sync byte swallowed after done, then a short frame carrying a sync byte as payload
	localparam logic [7:0] OPENING [21] = '{
		8'h00, 8'hFF, 8'h55,
		8'hAA, 8'h00, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hAA,
		8'hAA, 8'h12, 8'h34, 8'h56, 8'h02, 8'hAA, 8'hFF, 8'hA5, 8'h5A, 8'h00
	};

	// one result transaction as seen on the output ports
	typedef struct packed {
		phase_t      phase;
		logic        pvalid;
		logic [7:0]  pbyte;
		logic [5:0]  pindex;
		logic        done;
		logic [7:0]  sender;
		logic [7:0]  target;
		logic [7:0]  cmd;
		logic [6:0]  len;
		logic [15:0] chk;
	} parse_result_t;

	// parser state tracking and in-order result checking
	class frame_scoreboard;
		phase_t        ph;
		logic [7:0]    sync_pat;
		logic [7:0]    sender;
		logic [7:0]    target;
		logic [7:0]    cmd;
		logic [6:0]    len;
		logic [6:0]    pay_count;
		logic [15:0]   chk;
		parse_result_t frame_views[$];
		int            errors;
		int            results_seen;

		function new();
			ph = PH_HUNT;
			sync_pat = SYNC_RESET;
			sender = '0;
			target = '0;
			cmd = '0;
			len = '0;
			pay_count = '0;
			chk = '0;
			errors = 0;
			results_seen = 0;
		endfunction

		function void set_sync(logic [7:0] v);
			sync_pat = v;
		endfunction

		function int pending();
			return frame_views.size();
		endfunction

		// step the parser by one byte and queue the result it produces
		function void advance_parser(logic [7:0] b);
			parse_result_t r;
			r = '0;
			case (ph)
				PH_HUNT: begin
					if (b == sync_pat) begin
						sender = '0;
						target = '0;
						cmd = '0;
						len = '0;
						pay_count = '0;
						chk = '0;
						ph = PH_SENDER;
					end
				end
				PH_SENDER: begin
					sender = b;
					ph = PH_TARGET;
				end
				PH_TARGET: begin
					target = b;
					ph = PH_COMMAND;
				end
				PH_COMMAND: begin
					cmd = b;
					ph = PH_LENGTH;
				end
				PH_LENGTH: begin
					// oversized lengths saturate, zero skips the payload
					len = (b > MAX_LEN) ? 7'(MAX_LEN) : b[6:0];
					ph = (len == 0) ? PH_CHK_HI : PH_PAYLOAD;
				end
				PH_PAYLOAD: begin
					r.pvalid = 1'b1;
					r.pbyte = b;
					r.pindex = pay_count[5:0];
					pay_count = pay_count + 7'd1;
					if (pay_count >= len)
						ph = PH_CHK_HI;
				end
				PH_CHK_HI: begin
					chk = {b, 8'h00};
					ph = PH_CHK_LO;
				end
				PH_CHK_LO: begin
					chk = {chk[15:8], b};
					r.done = 1'b1;
					ph = PH_DONE;
				end
				default: ph = PH_HUNT;
			endcase
			r.phase = ph;
			r.sender = sender;
			r.target = target;
			r.cmd = cmd;
			r.len = len;
			r.chk = chk;
			frame_views.push_back(r);
		endfunction

		task report(string msg);
			$display("mismatch: %s", msg);
			errors++;
		endtask

		task compare_field(string name, logic [15:0] got, logic [15:0] want);
			if (got !== want)
				report($sformatf("result %0d %s got 0x%0h expected 0x%0h",
					results_seen, name, got, want));
		endtask

		task check_result(parse_result_t seen);
			parse_result_t want;
			results_seen++;
			if (frame_views.size() == 0) begin
				report($sformatf("result %0d arrived with nothing expected", results_seen));
				return;
			end
			want = frame_views.pop_front();
			compare_field("phase_after", 16'(seen.phase), 16'(want.phase));
			compare_field("payload_valid", 16'(seen.pvalid), 16'(want.pvalid));
			compare_field("payload_byte", 16'(seen.pbyte), 16'(want.pbyte));
			compare_field("payload_index", 16'(seen.pindex), 16'(want.pindex));
			compare_field("frame_done", 16'(seen.done), 16'(want.done));
			compare_field("src_id", 16'(seen.sender), 16'(want.sender));
			compare_field("dst_id", 16'(seen.target), 16'(want.target));
			compare_field("command", 16'(seen.cmd), 16'(want.cmd));
			compare_field("payload_length", 16'(seen.len), 16'(want.len));
			compare_field("check_word", seen.chk, want.chk);
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [7:0]  cfg_wdata;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  rx_byte;
	logic        out_valid;
	logic        out_ready;
	logic [3:0]  phase_after;
	logic        payload_valid;
	logic [7:0]  payload_byte;
	logic [5:0]  payload_index;
	logic        frame_done;
	logic [7:0]  src_id;
	logic [7:0]  dst_id;
	logic [7:0]  command;
	logic [6:0]  payload_length;
	logic [15:0] check_word;

	frame_scoreboard sb;
	logic [7:0]      cur_sync;
	int              bytes_sent = 0;
	int              quiet_cycles = 0;
	bit              no_idle = 1'b0;
	bit              hold_req = 1'b0;

	sync_framed_packet_parser_unit #(.MAX_PAYLOAD(MAX_LEN)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.phase_after(phase_after),
		.payload_valid(payload_valid),
		.payload_byte(payload_byte),
		.payload_index(payload_index),
		.frame_done(frame_done),
		.src_id(src_id),
		.dst_id(dst_id),
		.command(command),
		.payload_length(payload_length),
		.check_word(check_word)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// idle length: mostly none or short, now and then long
	function automatic int pick_gap();
		int r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// length byte: mostly short frames, some full range, a few oversized
	function automatic int random_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return $urandom_range(0, 8);
		if (r < 85)
			return $urandom_range(9, MAX_LEN);
		if (r < 93)
			case ($urandom_range(0, 3))
				0: return 0;
				1: return 1;
				2: return MAX_LEN - 1;
				default: return MAX_LEN;
			endcase
		return $urandom_range(MAX_LEN + 1, 255);
	endfunction

	// offer one byte, returns just after the accepting edge
	task automatic push_byte(input logic [7:0] b);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.advance_parser(b);
		bytes_sent++;
	endtask

	// well formed frame with random content and a trailing byte that gets swallowed
	task automatic send_frame(input int len_byte);
		int n;
		int k;
		logic [15:0] chk;
		push_byte(cur_sync);
		repeat (3) push_byte(8'($urandom_range(0, 255)));
		push_byte(8'(len_byte));
		n = (len_byte > MAX_LEN) ? MAX_LEN : len_byte;
		for (k = 0; k < n; k++)
			push_byte(($urandom_range(0, 9) == 0) ? cur_sync : 8'($urandom_range(0, 255)));
		case ($urandom_range(0, 9))
			0: chk = 16'h0000;
			1: chk = 16'hFFFF;
			default: chk = 16'($urandom_range(0, 65535));
		endcase
		push_byte(chk[15:8]);
		push_byte(chk[7:0]);
		push_byte(($urandom_range(0, 3) == 0) ? cur_sync : 8'($urandom_range(0, 255)));
	endtask

	// mostly frames, some line noise and frames cut short
	task automatic run_random(input int n);
		int stop_at;
		int r;
		stop_at = bytes_sent + n;
		while (bytes_sent < stop_at) begin
			r = $urandom_range(0, 99);
			if (r < 78) begin
				send_frame(random_length());
			end else if (r < 90) begin
				repeat ($urandom_range(1, 6)) push_byte(8'($urandom_range(0, 255)));
			end else begin
				// truncated frame, the next bytes get absorbed as its fields
				push_byte(cur_sync);
				repeat ($urandom_range(1, 5)) push_byte(8'($urandom_range(0, 255)));
			end
		end
	endtask

	// stop offering and wait for every outstanding result
	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	task automatic write_sync(input logic [7:0] v);
		drain_results();
		repeat (4) @(negedge clk);
		cfg_wdata <= v;
		cfg_we <= 1'b1;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.set_sync(v);
		cur_sync = v;
	endtask

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
				out_ready <= 1'b1;
			end else begin
				int stall;
				stall = pick_gap();
				if (stall > 0) begin
					out_ready <= 1'b0;
					repeat (stall) @(negedge clk);
				end
				out_ready <= 1'b1;
			end
		end
	end

	// result transaction monitor
	always @(posedge clk) begin : result_monitor
		parse_result_t seen;
		if (arst_n && out_valid && out_ready) begin
			seen.phase = phase_t'(phase_after);
			seen.pvalid = payload_valid;
			seen.pbyte = payload_byte;
			seen.pindex = payload_index;
			seen.done = frame_done;
			seen.sender = src_id;
			seen.target = dst_id;
			seen.cmd = command;
			seen.len = payload_length;
			seen.chk = check_word;
			sb.check_result(seen);
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("sync_framed_packet_parser_unit_tb failed");
			$finish;
		end
	end

	// main sequence
	initial begin
		sb = new();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = SYNC_RESET;
		in_valid = 1'b0;
		rx_byte = 8'h00;
		cur_sync = SYNC_RESET;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		foreach (OPENING[i])
			push_byte(OPENING[i]);

		// reset sync value: oversized, full and just-over lengths first
		send_frame(255);
		send_frame(MAX_LEN);
		send_frame(MAX_LEN + 1);
		run_random(100);
		hold_req = 1'b1;
		run_random(130);
		drain_results();
		run_random(130);

		// sync at the low extreme
		write_sync(8'h00);
		run_random(300);

		// sync at the high extreme, first part without any idling
		write_sync(8'hFF);
		no_idle = 1'b1;
		run_random(180);
		no_idle = 1'b0;
		run_random(220);

		// random sync value with another long hold-off
		write_sync(8'($urandom_range(1, 254)));
		run_random(200);
		hold_req = 1'b1;
		run_random(200);

		drain_results();
		repeat (10) @(posedge clk);
		if (sb.errors == 0)
			$display("sync_framed_packet_parser_unit_tb passed");
		else
			$display("sync_framed_packet_parser_unit_tb failed");
		$finish;
	end

endmodule
